[rtl/mpe_pkg.sv]
// Shared widths and constants of the Mandelbrot pair escape-count unit.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package mpe_pkg;

   // Fixed-point format of all real values (signed, FRAC_BITS fraction bits)
   localparam int FRAC_BITS  = 28;
   // Bits of each reported count
   localparam int COUNT_BITS = 16;

   // Working width of z and c: a second point can reach 2^32, and one update
   // adds at most 2^30 to it.
   localparam int Z_W    = 36;
   // Multiplier operand magnitude width: 2*|zi| <= 2^30 once the bound test passed
   localparam int MAG_W  = 31;
   localparam int PROD_W = 2 * MAG_W;
   // Truncated product width: |2*zi*zr| <= 8.0 in Q4.28
   localparam int SQ_W   = 32;
   // Iteration counter holds max_iterations + 1
   localparam int CNT_W  = 17;

   localparam int MAX_ITER_W = 16;
   localparam int STEP_W     = 31;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_STEP = 1'b1;

   localparam logic [MAX_ITER_W-1:0] MAX_ITER_RESET   = 16'd255;
   localparam logic [STEP_W-1:0]     PIXEL_STEP_RESET = 31'd1048576;

   localparam logic signed [Z_W-1:0] TWO_FX     = Z_W'(64'd2 << FRAC_BITS);
   localparam logic signed [Z_W-1:0] NEG_TWO_FX = -TWO_FX;
   localparam logic [SQ_W:0]         FOUR_FX    = (SQ_W + 1)'(64'd4 << FRAC_BITS);
   localparam logic [CNT_W-1:0]      COUNT_START = CNT_W'(2);

   typedef logic [MAG_W-1:0]  mag_type;
   typedef logic [PROD_W-1:0] prod_type;

   // Magnitude of a working value; callers guarantee it is below 2^MAG_W
   function automatic mag_type fx_mag(input logic signed [Z_W-1:0] v);
      logic [Z_W-1:0] a;
      a = v[Z_W-1] ? Z_W'(-v) : Z_W'(v);
      return a[MAG_W-1:0];
   endfunction

endpackage

[rtl/mpe_mul.sv]
// Shared unsigned magnitude multiplier with a registered product.
// Depends on mpe_pkg.
`timescale 1ns / 1ps

module mpe_mul (
   input  logic             clock,
   input  mpe_pkg::mag_type op_a,
   input  mpe_pkg::mag_type op_b,
   output mpe_pkg::prod_type prod
);
   import mpe_pkg::*;

   prod_type prod_ff;
   prod_type prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[rtl/mandelbrot_pair_escape_count_unit.sv]
// Top level of the Mandelbrot pair escape-count unit: sequencer, z state,
// configuration registers and result register. Depends on mpe_pkg, mpe_mul.
`timescale 1ns / 1ps

// Usage
//   req_ channel: one transfer carries a point c (c_real, c_imag, signed Q4.28).
//   rsp_ channel: one transfer per request carries the escape counts of c and
//     of c + pixel_step (same imaginary part), low 16 bits each.
//   csr_ port: write max_iterations (index 0) or pixel_step (index 1) while idle.
// Sequencing
//   One iteration of z = z^2 + c runs through ST_TEST, ST_SQI, ST_CROSS and
//   ST_UPD: three passes through the single shared 31x31 multiplier (zr^2,
//   zi^2, 2*zi*zr) and one update step. req_tready is high only while no
//   item is in work.
// Reset
//   Synchronous, active high: the sequencer returns to idle, the result
//   register empties, max_iterations = 255 and pixel_step = 1.0/256.
// Back-pressure
//   The result register frees req_tready as soon as a result is parked, so a
//   new point is taken while rsp_tready is low. If the next result is done
//   before the previous one was taken, the unit holds it until rsp_tready.
module mandelbrot_pair_escape_count_unit (
   input  logic        clock,
   input  logic        reset,
   // Request: [31:0] c_real, [63:32] c_imag
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // Response: [15:0] count_first, [31:16] count_second
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // Configuration writes
   input  logic                             csr_we,
   input  logic [mpe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mpe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mpe_pkg::*;

   // Sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;  // wait for a request
   localparam logic [2:0] ST_TEST  = 3'd1;  // limit and bound test, issue zr*zr
   localparam logic [2:0] ST_SQI   = 3'd2;  // take zr^2, issue zi*zi
   localparam logic [2:0] ST_CROSS = 3'd3;  // take zi^2, escape test, issue 2zi*zr
   localparam logic [2:0] ST_UPD   = 3'd4;  // form the new z, advance count
   localparam logic [2:0] ST_DONE  = 3'd5;  // close a point

   logic [2:0]              state_ff, state_in;
   logic                    point_ff, point_in;   // 0: first point, 1: second
   logic signed [Z_W-1:0]   cr_ff, cr_in;
   logic signed [31:0]      ci_ff, ci_in;
   logic signed [Z_W-1:0]   zr_ff, zr_in;
   logic signed [Z_W-1:0]   zi_ff, zi_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [SQ_W-1:0]         sr_ff, sr_in;
   logic [SQ_W-1:0]         si_ff, si_in;
   logic [COUNT_BITS-1:0]   first_ff, first_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_data_ff, rsp_data_in;
   logic [MAX_ITER_W-1:0]   max_iter_ff, max_iter_in;
   logic [STEP_W-1:0]       step_ff, step_in;

   mag_type                 mag_zr, mag_zi;
   mag_type                 op_a, op_b;
   prod_type                prod;
   logic [SQ_W-1:0]         prod_fx;
   logic [SQ_W:0]           mag_sum;
   logic                    out_of_bounds;
   logic                    within_limit;
   logic signed [Z_W-1:0]   cross_fx;
   logic signed [Z_W-1:0]   ci_ext;
   logic                    out_free;

   // Single shared multiplier; product is valid in the cycle after issue
   mpe_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign mag_zr  = fx_mag(zr_ff);
   assign mag_zi  = fx_mag(zi_ff);
   // Truncate toward zero: magnitudes are shifted, sign applied afterwards
   assign prod_fx = prod[FRAC_BITS +: SQ_W];
   assign mag_sum = {1'b0, sr_ff} + {1'b0, prod_fx};
   assign ci_ext  = Z_W'(ci_ff);
   assign cross_fx = (zi_ff[Z_W-1] != zr_ff[Z_W-1]) ? -Z_W'(prod_fx) : Z_W'(prod_fx);

   // A part beyond +-2.0 escapes at once and keeps the operands narrow
   assign out_of_bounds = (zr_ff > TWO_FX) || (zr_ff < NEG_TWO_FX) ||
                          (zi_ff > TWO_FX) || (zi_ff < NEG_TWO_FX);
   assign within_limit  = (n_ff <= CNT_W'(max_iter_ff));
   assign out_free      = !rsp_valid_ff || rsp_tready;

   // Multiplier operand selection
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_TEST: begin
            op_a = mag_zr;
            op_b = mag_zr;
         end
         ST_SQI: begin
            op_a = mag_zi;
            op_b = mag_zi;
         end
         ST_CROSS: begin
            op_a = {mag_zi[MAG_W-2:0], 1'b0};
            op_b = mag_zr;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      point_in     = point_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      n_in         = n_ff;
      sr_in        = sr_ff;
      si_in        = si_ff;
      first_in     = first_ff;
      rsp_data_in  = rsp_data_ff;
      // drop the result once the receiver takes it
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cr_in    = Z_W'($signed(req_tdata[31:0]));
               zr_in    = Z_W'($signed(req_tdata[31:0]));
               ci_in    = $signed(req_tdata[63:32]);
               zi_in    = Z_W'($signed(req_tdata[63:32]));
               n_in     = COUNT_START;
               point_in = 1'b0;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (!within_limit || out_of_bounds) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQI;
            end
         end
         ST_SQI: begin
            sr_in    = prod_fx;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            si_in = prod_fx;
            if (mag_sum > FOUR_FX) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            zi_in    = cross_fx + ci_ext;
            zr_in    = Z_W'(sr_ff) - Z_W'(si_ff) + cr_ff;
            n_in     = n_ff + CNT_W'(1);
            state_in = ST_TEST;
         end
         ST_DONE: begin
            if (!point_ff) begin
               // start the point one pixel step to the right
               first_in = n_ff[COUNT_BITS-1:0];
               cr_in    = cr_ff + Z_W'(step_ff);
               zr_in    = cr_ff + Z_W'(step_ff);
               zi_in    = ci_ext;
               n_in     = COUNT_START;
               point_in = 1'b1;
               state_in = ST_TEST;
            end else if (out_free) begin
               rsp_data_in  = {n_ff[COUNT_BITS-1:0], first_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration registers, masked to their widths
   always_comb begin
      max_iter_in = max_iter_ff;
      step_in     = step_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_ITER:   max_iter_in = csr_wdata[MAX_ITER_W-1:0];
            CSR_PIXEL_STEP: step_in     = csr_wdata[STEP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_iter_ff  <= MAX_ITER_RESET;
         step_ff      <= PIXEL_STEP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_iter_ff  <= max_iter_in;
         step_ff      <= step_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      point_ff    <= point_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      n_ff        <= n_in;
      sr_ff       <= sr_in;
      si_ff       <= si_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/mpe_checker.sv]
// Port-level checks of the Mandelbrot pair escape-count unit, bound to the top.
// Depends on mandelbrot_pair_escape_count_unit.
`timescale 1ns / 1ps

module mpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its counts
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Reset empties the result register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   // One item at a time: an accepted transfer closes the request side
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in work");

   // A result never appears right after a request transfer
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result too early after request");

endmodule

bind mandelbrot_pair_escape_count_unit mpe_checker u_mpe_checker (.*);
